// ----- rtl/sfd_pkg.sv -----
// shared types, constants and arithmetic helpers of the stereo feedback delay
package sfd_pkg;

	localparam int SFD_DEPTH    = 65536;
	localparam int SFD_CHANNELS = 2;

	localparam int SAMPLE_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;

	// bit-serial multiplier operand and product widths
	localparam int SMUL_AW = 18;
	localparam int SMUL_GW = 16;
	localparam int SMUL_PW = SMUL_AW + SMUL_GW;

	localparam logic [15:0] DELAY_RST = 16'd24000;
	localparam logic [14:0] FB_RST    = 15'd16384;
	localparam logic [15:0] WET_RST   = 16'd16384;
	localparam logic [15:0] DRY_RST   = 16'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_SAMPLES,
		REG_FEEDBACK_GAIN,
		REG_WET_GAIN,
		REG_DRY_GAIN
	} sfd_reg_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_ADDR,
		ST_READ,
		ST_LOAD,
		ST_MUL1,
		ST_RND1,
		ST_LOAD2,
		ST_MUL2,
		ST_RND2,
		ST_WRITE
	} sfd_state_t;

	typedef struct packed {
		logic start;
		logic step;
	} sfd_smul_ctl_t;

	// q1.15 product rounding, half up, floor after the shift
	function automatic logic signed [18:0] round_q15(input logic signed [SMUL_PW-1:0] p);
		logic signed [SMUL_PW-1:0] s;
		s = p + SMUL_PW'(16384);
		return s[SMUL_PW-1:15];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		if (v > 20'sd32767) begin
			return 16'sh7fff;
		end else if (v < -20'sd32768) begin
			return 16'sh8000;
		end else begin
			return v[15:0];
		end
	endfunction

endpackage

// ----- rtl/sfd_if.sv -----
// stream interfaces for stereo sample requests and results
interface sfd_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sfd_pkg::SAMPLE_W-1:0] left_in;
	logic signed [sfd_pkg::SAMPLE_W-1:0] right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [sfd_pkg::SAMPLE_W-1:0] left_out;
	logic signed [sfd_pkg::SAMPLE_W-1:0] right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

// ----- rtl/sfd_ram.sv -----
// generic simple dual-port ram, one write port, one registered read port
module sfd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/sfd_smul.sv -----
// bit-serial signed by unsigned multiplier, one multiplier bit per step
module sfd_smul #(
	parameter int AW = sfd_pkg::SMUL_AW,
	parameter int GW = sfd_pkg::SMUL_GW
) (
	input  logic                      clk,
	input  sfd_pkg::sfd_smul_ctl_t    ctl,
	input  logic signed [AW-1:0]      a,
	input  logic [GW-1:0]             g,
	output logic signed [AW+GW-1:0]   p
);

	import sfd_pkg::*;

	logic signed [AW-1:0] a_q;
	logic signed [AW:0]   hi_q;
	logic [GW-1:0]        lo_q;
	logic signed [AW+1:0] sum;

	// add the multiplicand into the upper half when the current bit is set
	assign sum = (AW+2)'(hi_q) + (lo_q[0] ? (AW+2)'(a_q) : '0);

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= g;
		end else if (ctl.step) begin
			hi_q <= sum[AW+1:1];
			lo_q <= {sum[0], lo_q[GW-1:1]};
		end
	end

	assign p = {hi_q[AW-1:0], lo_q};

endmodule

// ----- rtl/stereo_feedback_delay.sv -----
// stereo feedback echo on a circular delay memory, top level
//
// din takes one left and one right sample per request (valid/ready); dout
// gives one echoed left/right pair per request through an output register.
// configuration is a plain write port: cfg_we, cfg_idx, cfg_wdata, taken on
// any edge with cfg_we high, meant to be used only while the block is idle.
// after reset the delay memory is swept to zero, one entry per cycle, over all
// DEPTH entries (65536 at the default); din.ready stays low during the sweep.
// each request then runs through the reduction of the delay modulo DEPTH, the
// address and read states, and two 16-step bit-serial multiplication passes
// per channel: wet gain first, then dry gain and feedback gain side by side.
// both channels run in parallel lanes. the result sits in the output register
// until taken; a new request is accepted meanwhile, but its result waits in
// the write state, holding the write index, for as long as the receiver
// stalls.
module stereo_feedback_delay #(
	parameter int DEPTH    = sfd_pkg::SFD_DEPTH,
	parameter int CHANNELS = sfd_pkg::SFD_CHANNELS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sfd_in_if.sink                       din,
	sfd_out_if.source                    dout,
	input  logic                         cfg_we,
	input  logic [sfd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [sfd_pkg::CFG_W-1:0]    cfg_wdata
);

	import sfd_pkg::*;

	localparam int IW = $clog2(DEPTH);
	// steps of the restoring reduction of delay_samples modulo DEPTH
	localparam int QB        = $clog2((65536 + DEPTH - 1) / DEPTH);
	localparam int MOD_STEPS = (QB > 1) ? QB : 1;
	localparam int MCW       = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
	localparam int DVW       = IW + MOD_STEPS;
	localparam logic [DVW-1:0] DIV_INIT = DVW'(DEPTH * (2 ** (MOD_STEPS - 1)));
	localparam int SW = ((IW > 16) ? IW : 16) + 2;
	localparam int BW = $clog2(SMUL_GW);
	localparam logic [BW-1:0] BIT_LAST = BW'(SMUL_GW - 1);

	sfd_state_t state_q, state_d;

	// configuration registers
	logic [15:0] delay_q;
	logic [14:0] fb_q;
	logic [15:0] wet_q;
	logic [15:0] dry_q;

	logic [IW-1:0]  w_q;
	logic [IW-1:0]  clr_q;
	logic [IW-1:0]  r_q;
	logic [15:0]    dm_q;
	logic [DVW-1:0] div_q;
	logic [MCW-1:0] mod_cnt_q;
	logic [BW-1:0]  bit_q;
	logic [SW-1:0]  raw_addr;

	logic out_valid_q;
	logic signed [15:0] dout_l_q, dout_r_q;
	logic signed [15:0] lane_res [CHANNELS];

	// sequencer outputs
	logic          in_ready;
	logic          clearing;
	logic          ram_we;
	logic          out_load;
	sfd_smul_ctl_t mul0_ctl, mul1_ctl;

	logic in_acc;
	assign in_acc = din.valid && in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == IW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (din.valid) state_d = ST_MOD;
			end
			ST_MOD: begin
				if (mod_cnt_q == '0) state_d = ST_ADDR;
			end
			ST_ADDR:  state_d = ST_READ;
			ST_READ:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_MUL1;
			ST_MUL1: begin
				if (bit_q == BIT_LAST) state_d = ST_RND1;
			end
			ST_RND1:  state_d = ST_LOAD2;
			ST_LOAD2: state_d = ST_MUL2;
			ST_MUL2: begin
				if (bit_q == BIT_LAST) state_d = ST_RND2;
			end
			ST_RND2:  state_d = ST_WRITE;
			ST_WRITE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		clearing       = (state_q == ST_CLEAR);
		ram_we         = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
		mul0_ctl.start = (state_q == ST_LOAD) || (state_q == ST_LOAD2);
		mul0_ctl.step  = (state_q == ST_MUL1) || (state_q == ST_MUL2);
		mul1_ctl.start = (state_q == ST_LOAD2);
		mul1_ctl.step  = (state_q == ST_MUL2);
		out_load       = (state_q == ST_WRITE) && (!out_valid_q || dout.ready);
	end

	assign din.ready = in_ready;

	// read address: write index minus reduced delay, wrapped at DEPTH
	always_comb begin
		raw_addr = SW'(w_q) + SW'(DEPTH) - SW'(dm_q);
		if (raw_addr >= SW'(DEPTH)) begin
			raw_addr = raw_addr - SW'(DEPTH);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			delay_q     <= DELAY_RST;
			fb_q        <= FB_RST;
			wet_q       <= WET_RST;
			dry_q       <= DRY_RST;
			w_q         <= '0;
			clr_q       <= '0;
			mod_cnt_q   <= '0;
			bit_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_idx)
					REG_DELAY_SAMPLES: delay_q <= cfg_wdata;
					REG_FEEDBACK_GAIN: fb_q    <= cfg_wdata[14:0];
					REG_WET_GAIN:      wet_q   <= cfg_wdata;
					REG_DRY_GAIN:      dry_q   <= cfg_wdata;
					default: ;
				endcase
			end

			if (clearing) begin
				clr_q <= clr_q + 1'b1;
			end

			if (in_acc) begin
				mod_cnt_q <= MCW'(MOD_STEPS - 1);
			end else if (state_q == ST_MOD && mod_cnt_q != '0) begin
				mod_cnt_q <= mod_cnt_q - 1'b1;
			end

			if (mul0_ctl.start) begin
				bit_q <= '0;
			end else if (mul0_ctl.step) begin
				bit_q <= bit_q + 1'b1;
			end

			// write index moves on once the result is handed over
			if (out_load) begin
				w_q <= (w_q == IW'(DEPTH - 1)) ? '0 : w_q + 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// delay reduction and address datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dm_q  <= delay_q;
			div_q <= DIV_INIT;
		end else if (state_q == ST_MOD) begin
			if (DVW'(dm_q) >= div_q) begin
				dm_q <= dm_q - 16'(div_q);
			end
			div_q <= div_q >> 1;
		end
		if (state_q == ST_ADDR) begin
			r_q <= raw_addr[IW-1:0];
		end
	end

	// one lane per channel, each with its own delay memory and two multipliers
	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic signed [15:0]        x_in;
		logic signed [15:0]        x_q;
		logic signed [17:0]        wd_q;
		logic signed [15:0]        res_q;
		logic signed [15:0]        st_q;
		logic signed [15:0]        mix;
		logic [15:0]               rdata;
		logic [15:0]               wdata;
		logic [IW-1:0]             waddr;
		logic signed [SMUL_AW-1:0] mul0_a;
		logic [SMUL_GW-1:0]        mul0_g;
		logic signed [SMUL_PW-1:0] p0, p1;
		logic signed [18:0]        rnd0, rnd1;

		assign x_in = (c == 0) ? din.left_in : din.right_in;

		// wet-scaled echo plus the dry sample
		assign mix  = sat16(20'(x_q) + 20'(wd_q));
		assign rnd0 = round_q15(p0);
		assign rnd1 = round_q15(p1);

		assign mul0_a = (state_q == ST_LOAD) ? SMUL_AW'(signed'(rdata)) : SMUL_AW'(mix);
		assign mul0_g = (state_q == ST_LOAD) ? wet_q : dry_q;

		assign wdata = clearing ? '0 : st_q;
		assign waddr = clearing ? clr_q : w_q;

		sfd_ram #(
			.WIDTH (16),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ram_we),
			.waddr (waddr),
			.wdata (wdata),
			.raddr (r_q),
			.rdata (rdata)
		);

		// wet gain, then dry gain on the mix
		sfd_smul u_mul0 (
			.clk (clk),
			.ctl (mul0_ctl),
			.a   (mul0_a),
			.g   (mul0_g),
			.p   (p0)
		);

		// feedback gain on the wet-scaled echo
		sfd_smul u_mul1 (
			.clk (clk),
			.ctl (mul1_ctl),
			.a   (SMUL_AW'(wd_q)),
			.g   ({1'b0, fb_q}),
			.p   (p1)
		);

		always_ff @(posedge clk) begin
			if (in_acc) begin
				x_q <= x_in;
			end
			if (state_q == ST_RND1) begin
				wd_q <= rnd0[17:0];
			end
			if (state_q == ST_RND2) begin
				res_q <= sat16(20'(rnd0));
				st_q  <= sat16(20'(x_q) + 20'(rnd1));
			end
		end

		assign lane_res[c] = res_q;
	end

	// output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			dout_l_q <= lane_res[0];
			dout_r_q <= (CHANNELS > 1) ? lane_res[CHANNELS-1] : '0;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.left_out  = dout_l_q;
	assign dout.right_out = dout_r_q;

	// reduced delay is inside the memory before the address is formed
	a_dm_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADDR) |-> (SW'(dm_q) < SW'(DEPTH)))
		else $error("reduced delay not below depth");

	// nothing moves on either channel while the memory is being cleared
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!din.ready && !dout.valid))
		else $error("channel active during clearing pass");

	// a handed-over result shows up and the sequencer returns to idle
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (dout.valid && state_q == ST_IDLE))
		else $error("result hand-over did not complete");

	// the wet-gain multiplication starts from a fresh bit count
	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |=> (state_q == ST_MUL1 && bit_q == '0))
		else $error("multiplier sequence misaligned");

endmodule

// ----- tb/sv/tb_stereo_feedback_delay.sv -----
// self-checking testbench of the stereo feedback delay against its own echo predictor
`timescale 1ns / 100ps

module tb_stereo_feedback_delay;
	import sfd_pkg::*;

	localparam int DEPTH    = SFD_DEPTH;
	localparam int CHANNELS = SFD_CHANNELS;

	// the limit covers the reset sweep and about a thousand
	// requests under heavy stalls, the long receiver hold and every drain
	localparam int unsigned CYCLE_LIMIT = 2000000;

	// ample for the block to settle before a register write or the final
	// verdict
	localparam int SETTLE_CYCLES = 64;

	// longest receiver hold-off, long enough for the block to fill and stall din
	localparam int RX_HOLD_CYCLES = 2000;

	typedef struct {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n;

	logic              cfg_we;
	sfd_reg_t          cfg_idx;
	logic [CFG_W-1:0]  cfg_wdata;

	sfd_in_if  din_if ();
	sfd_out_if dout_if ();

	stereo_feedback_delay dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din_if),
		.dout      (dout_if),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state: its own echo memory, write pointer and register copies
	logic signed [SAMPLE_W-1:0] echo_mem [CHANNELS][DEPTH];
	int                         wr_ptr = 0;
	logic [15:0]                cfg_delay    = DELAY_RST;
	logic [14:0]                cfg_feedback = FB_RST;
	logic [15:0]                cfg_wet      = WET_RST;
	logic [15:0]                cfg_dry      = DRY_RST;

	// echoed frames still owed by the block, oldest first
	frame_t pending_frames [$];

	int          fail_count  = 0;
	int unsigned cycle_count = 0;

	// idling knobs: percentages, plus a receiver hold-off counted down in cycles
	int tx_idle_pct  = 7;
	int rx_idle_pct  = 68;
	int rx_hold_left = 0;

	always #10 clk = ~clk;

	// ---------------------------------------------------------------------
	// echo arithmetic
	// ---------------------------------------------------------------------

	function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// q1.15 gain, round half up, floor after the shift (arithmetic shift floors)
	function automatic longint q15_scale(input longint a, input longint g);
		return (a * g + 64'sd16384) >>> 15;
	endfunction

	// one request through the echo: read the tap, mix, write back with feedback
	function automatic frame_t echo_predict(input logic signed [SAMPLE_W-1:0] left,
			input logic signed [SAMPLE_W-1:0] right);
		logic signed [SAMPLE_W-1:0] x [2];
		logic signed [SAMPLE_W-1:0] y [2];
		int     rd_ptr;
		longint tap;
		longint wet_tap;
		longint mix;
		frame_t res;
		x[0] = left;
		x[1] = right;
		// zero delay (or a multiple of DEPTH) reads the slot about to be overwritten
		rd_ptr = (wr_ptr + DEPTH - (int'(cfg_delay) % DEPTH)) % DEPTH;
		for (int c = 0; c < 2; c++) begin
			y[c] = '0;
			if (c < CHANNELS) begin
				tap     = echo_mem[c][rd_ptr];
				wet_tap = q15_scale(tap, cfg_wet);
				mix     = clip16(x[c] + wet_tap);
				y[c]    = clip16(q15_scale(mix, cfg_dry));
				// feedback works on the unsaturated wet tap
				echo_mem[c][wr_ptr] = clip16(x[c] + q15_scale(wet_tap, cfg_feedback));
			end
		end
		wr_ptr    = (wr_ptr + 1) % DEPTH;
		res.left  = y[0];
		res.right = y[1];
		return res;
	endfunction

	// ---------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'($urandom_range(64)) - 16'd32;
			default: return 16'($urandom);
		endcase
	endfunction

	// gain draw with both ends of the range and now and then a value beyond it
	function automatic logic [15:0] rand_gain(input int hi);
		case ($urandom_range(5))
			0: return 16'd0;
			1: return 16'(hi);
			2: return 16'($urandom_range(65535));
			default: return 16'($urandom_range(hi));
		endcase
	endfunction

	// offer one request, optionally after a gap, and predict it once accepted
	task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
			input logic signed [SAMPLE_W-1:0] right);
		int gap;
		gap = 0;
		// gaps reach past the length of a request so they land anywhere in it
		if ($urandom_range(99) < tx_idle_pct) begin
			gap = $urandom_range(60, 1);
		end
		if (gap > 0) begin
			din_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		din_if.valid    <= 1'b1;
		din_if.left_in  <= left;
		din_if.right_in <= right;
		do @(posedge clk); while (!din_if.ready);
		pending_frames.push_back(echo_predict(left, right));
	endtask

	// stop offering, wait for every owed frame, then let the block settle
	task automatic drain();
		din_if.valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// all four registers, one per cycle; only called with the block drained
	task automatic write_echo_regs(input logic [15:0] delay, input logic [15:0] feedback,
			input logic [15:0] wet, input logic [15:0] dry);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_DELAY_SAMPLES;
		cfg_wdata <= delay;
		@(posedge clk);
		cfg_idx   <= REG_FEEDBACK_GAIN;
		cfg_wdata <= feedback;
		@(posedge clk);
		cfg_idx   <= REG_WET_GAIN;
		cfg_wdata <= wet;
		@(posedge clk);
		cfg_idx   <= REG_DRY_GAIN;
		cfg_wdata <= dry;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_delay    = delay;
		cfg_feedback = feedback[14:0];	// top bit is not stored
		cfg_wet      = wet;
		cfg_dry      = dry;
	endtask

	task automatic write_random_regs();
		logic [15:0] delay;
		// mostly short delays so the taps land on samples already written
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: delay = 16'($urandom_range(300, 1));
			6, 7:             delay = 16'($urandom_range(16, 1));
			8:                delay = $urandom_range(1) ? 16'd0 : 16'hffff;
			default:          delay = 16'($urandom_range(65535));
		endcase
		write_echo_regs(delay, rand_gain(32440), rand_gain(32768), rand_gain(32768));
	endtask

	// idling knobs change away from the rising edge, then drive resumes there
	task automatic set_idling(input int tx_pct, input int rx_pct);
		@(negedge clk);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// reset register values: long delay onto cleared memory, unity dry gain
	task automatic test_reset_defaults();
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sh8000, 16'sh7fff);
		send_frame(16'sd0, 16'sd0);
		send_frame(-16'sd1, 16'sd1);
		send_frame(16'sd16384, -16'sd16385);
		drain();
	endtask

	// one-sample echo at full wet and near-maximum feedback, driven into saturation
	task automatic test_short_echo();
		write_echo_regs(16'd1, 16'd32440, 16'd32768, 16'd32768);
		repeat (3) send_frame(16'sh7fff, 16'sh8000);
		repeat (3) send_frame(16'sh8000, 16'sh7fff);
		repeat (2) send_frame(16'sd0, 16'sd0);
		drain();
	endtask

	// gains beyond their range, zero delay and the longest delay
	task automatic test_gain_extremes();
		// feedback top bit dropped; wet and dry applied as written
		write_echo_regs(16'd2, 16'hffff, 16'hffff, 16'hffff);
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sd1, -16'sd1);
		send_frame(16'sh8000, 16'sh7fff);
		send_frame(16'sd100, -16'sd100);
		drain();
		// zero delay means a full DEPTH of delay; zero gains silence the output
		write_echo_regs(16'd0, 16'd0, 16'd0, 16'd0);
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(16'sd12345, -16'sd12345);
		drain();
		// longest delay, read address wraps round the top of the memory
		write_echo_regs(16'hffff, 16'd16384, 16'd32768, 16'd16384);
		send_frame(16'sh7fff, 16'sh8000);
		send_frame(-16'sd2, 16'sd2);
		drain();
	endtask

	// several register settings, each with a run of random requests
	task automatic test_random_echo(input int settings, input int per_setting);
		repeat (settings) begin
			write_random_regs();
			repeat (per_setting) send_frame(rand_sample(), rand_sample());
			drain();
		end
	endtask

	// receiver holds off while requests keep coming, so din must stall
	task automatic test_receiver_hold();
		write_echo_regs(16'd3, 16'd30000, 16'd32768, 16'd32768);
		@(negedge clk);
		rx_hold_left = RX_HOLD_CYCLES;
		@(posedge clk);
		repeat (20) send_frame(rand_sample(), rand_sample());
		drain();
	endtask

	// sender pauses mid-stream until every owed frame is back
	task automatic test_sender_pause();
		write_random_regs();
		repeat (10) send_frame(rand_sample(), rand_sample());
		drain();
		repeat (10) send_frame(rand_sample(), rand_sample());
		drain();
	endtask

	// ---------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------

	initial begin
		foreach (echo_mem[c, i]) begin
			echo_mem[c][i] = '0;
		end
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_idx         = REG_DELAY_SAMPLES;
		cfg_wdata       = '0;
		din_if.valid    = 1'b0;
		din_if.left_in  = '0;
		din_if.right_in = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// the first request also waits out the memory sweep after reset
		test_reset_defaults();
		test_short_echo();
		test_gain_extremes();

		// sender rarely idle, receiver mostly stalled
		test_random_echo(3, 110);
		test_receiver_hold();

		// roles swapped
		set_idling(68, 7);
		test_random_echo(3, 110);
		test_sender_pause();

		// full rate on both sides
		set_idling(0, 0);
		test_random_echo(3, 110);

		drain();
		if (fail_count == 0) begin
			$display("PASS stereo_feedback_delay");
		end else begin
			$display("FAIL stereo_feedback_delay");
		end
		$finish;
	end

	// receiver: random stalls, or a forced hold-off while its counter runs
	initial begin
		dout_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// each taken frame against the oldest owed one, field by field
	always @(posedge clk) begin
		frame_t want;
		if (dout_if.valid && dout_if.ready) begin
			if (pending_frames.size() == 0) begin
				$display("%0t: unexpected frame left=%0d right=%0d", $time,
					dout_if.left_out, dout_if.right_out);
				fail_count++;
			end else begin
				want = pending_frames.pop_front();
				if (dout_if.left_out !== want.left) begin
					$display("%0t: left_out expected %0d actual %0d", $time,
						want.left, dout_if.left_out);
					fail_count++;
				end
				if (dout_if.right_out !== want.right) begin
					$display("%0t: right_out expected %0d actual %0d", $time,
						want.right, dout_if.right_out);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timeout, %0d frames still owed", $time, pending_frames.size());
		$display("FAIL stereo_feedback_delay");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/sfd_pkg.sv
rtl/sfd_if.sv
rtl/sfd_ram.sv
rtl/sfd_smul.sv
rtl/stereo_feedback_delay.sv
tb/sv/tb_stereo_feedback_delay.sv
